// File: src/rtpm_pkg.sv
// Shared types and codes for the route table prefix match core.
// Used by route_table_prefix_match_core; no dependencies.
package rtpm_pkg;

    localparam logic [31:0] HOP_NONE = 32'hffff_ffff;

    // request operations
    localparam logic [1:0] FN_LOOKUP = 2'd0;
    localparam logic [1:0] FN_ADD    = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_DUP  = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] lookup_address;
        logic [31:0] route_net;
        logic [31:0] route_mask;
        logic [31:0] route_hop;
        logic [4:0]  entry_index;
    } t_in_word;

    typedef struct packed {
        logic [31:0] next_hop;
        logic [2:0]  status;
        logic [5:0]  entries_used;
    } t_out_word;

    typedef struct packed {
        logic [31:0] mask;
        logic [31:0] net;
        logic [31:0] hop;
    } t_route;

    localparam int ROUTE_W = $bits(t_route);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ADD,
        S_DEL,
        S_RESP
    } t_state;

endpackage

// File: src/route_table_prefix_match_core.sv
// IPv4 route table with longest-prefix-match lookup, add and delete.
// Depends on rtpm_pkg and rtpm_ram.
//
// One request is worked on at a time. Every request sweeps the route RAM
// one entry per cycle through its single read port: a lookup or an add
// reads entries 0 to count-1, a delete moves entries index+1 to count-1
// down by one (read one entry, write it back one place lower in the next
// cycle). A request settled at acceptance (a refused request or a lookup
// on an empty table) sweeps nothing; the result of any request waits while
// the previous result is still held at a stalled output. The table needs
// no clearing pass after reset: only entries below the count are ever
// read. The result sits in an output register, so the next request is
// taken while it waits.
module route_table_prefix_match_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rtpm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rtpm_pkg::t_out_word o_out_word
);
    import rtpm_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int EU_W  = (CNT_W > 6) ? CNT_W : 6;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    t_in_word          r_req, n_req;
    logic              r_found, n_found;
    logic              r_dup, n_dup;
    logic [31:0]       r_best_mask, n_best_mask;
    logic [31:0]       r_res_hop, n_res_hop;
    logic [2:0]        r_res_status, n_res_status;
    logic              r_out_vld, n_out_vld;
    t_out_word         r_out, n_out;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_route            ram_wdata;
    logic [ROUTE_W-1:0] ram_rdata;
    t_route            rd_route;
    logic              in_accept;
    logic              issue;
    logic              scan_done;
    logic              del_bad;
    logic [EU_W-1:0]   cnt_wide;

    rtpm_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_route  = t_route'(ram_rdata);
    assign in_accept = i_in_valid && !o_in_stall;
    assign issue     = r_ptr < r_count;
    assign scan_done = !issue && !r_pend;
    assign del_bad   = (r_count == '0) ||
                       (CMP_W'(i_in_word.entry_index) >= CMP_W'(r_count));
    assign cnt_wide  = EU_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_pend_idx   <= n_pend_idx;
        r_req        <= n_req;
        r_found      <= n_found;
        r_dup        <= n_dup;
        r_best_mask  <= n_best_mask;
        r_res_hop    <= n_res_hop;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_pend       = 1'b0;
        n_pend_idx   = r_ptr[IDX_W-1:0];
        n_req        = r_req;
        n_found      = r_found;
        n_dup        = r_dup;
        n_best_mask  = r_best_mask;
        n_res_hop    = r_res_hop;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_count[IDX_W-1:0];
        ram_wdata    = '{mask: r_req.route_mask, net: r_req.route_net,
                         hop: r_req.route_hop};

        // drop the output word once taken
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        // sweep: issue one read per cycle, process its data the next cycle
        if (r_state == S_LOOK || r_state == S_ADD || r_state == S_DEL) begin
            n_pend = issue;
            if (issue) begin
                n_ptr = r_ptr + CNT_W'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req       = i_in_word;
                    n_found     = 1'b0;
                    n_dup       = 1'b0;
                    n_best_mask = '0;
                    n_res_hop   = HOP_NONE;
                    n_ptr       = '0;
                    n_state     = S_RESP;
                    unique case (i_in_word.func)
                        FN_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res_status = ST_MISS;
                            end else begin
                                n_state = S_LOOK;
                            end
                        end
                        FN_ADD: begin
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        FN_DELETE: begin
                            if (del_bad) begin
                                n_res_status = ST_BAD;
                            end else begin
                                n_ptr   = CNT_W'(i_in_word.entry_index) + CNT_W'(1);
                                n_state = S_DEL;
                            end
                        end
                        default: begin
                            n_res_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                // later entries win ties, hence >=
                if (r_pend && ((rd_route.mask & r_req.lookup_address) == rd_route.net)
                        && (!r_found || rd_route.mask >= r_best_mask)) begin
                    n_found     = 1'b1;
                    n_best_mask = rd_route.mask;
                    n_res_hop   = rd_route.hop;
                end
                if (scan_done) begin
                    n_res_status = r_found ? ST_DONE : ST_MISS;
                    n_state      = S_RESP;
                end
            end
            S_ADD: begin
                if (r_pend && rd_route.net == r_req.route_net
                        && rd_route.mask == r_req.route_mask
                        && rd_route.hop == r_req.route_hop) begin
                    n_dup = 1'b1;
                end
                if (scan_done) begin
                    if (r_dup) begin
                        n_res_status = ST_DUP;
                    end else begin
                        ram_we       = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_res_status = ST_DONE;
                    end
                    n_state = S_RESP;
                end
            end
            S_DEL: begin
                // write each read entry back one place lower
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_idx - IDX_W'(1);
                    ram_wdata = rd_route;
                end
                if (scan_done) begin
                    n_count      = r_count - CNT_W'(1);
                    n_res_status = ST_DONE;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld        = 1'b1;
                    n_out.next_hop   = r_res_hop;
                    n_out.status     = r_res_status;
                    n_out.entries_used = cnt_wide[5:0];
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("route count beyond table depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_ADD || r_state == S_DEL))
        else $error("table write outside add or delete");

    a_fail_no_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_DONE) |-> o_out_word.next_hop == HOP_NONE)
        else $error("refused request carries a next hop");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_in_stall && r_state != S_IDLE))
        else $error("request accepted while another is in work");
`endif
endmodule

// File: src/rtpm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rtpm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: tb/sv/tb_route_table_prefix_match_core.sv
// Self-checking bench for route_table_prefix_match_core: a directed table, a fill to
// capacity, then random requests checked against a local copy of the route table.
// Depends on rtpm_pkg and route_table_prefix_match_core.
module tb_route_table_prefix_match_core;
    import rtpm_pkg::*;

    localparam int ROUTE_SLOTS = 32;
    localparam int RANDOM_WORDS = 590;
    localparam int TAIL_WORDS = 60;
    localparam int DRAIN_CYCLES = ROUTE_SLOTS + 8;
    localparam int MAX_MSGS = 100;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // local copy of the route table
    logic [31:0] tbl_mask [ROUTE_SLOTS];
    logic [31:0] tbl_net  [ROUTE_SLOTS];
    logic [31:0] tbl_hop  [ROUTE_SLOTS];
    int          route_count = 0;

    t_out_word pending_results[$];
    t_dir_row  dir_rows[$];
    int        mismatches = 0;
    bit        quiet_tail = 1'b0;
    bit        send_calm = 1'b0;
    bit        stall_calm = 1'b0;
    bit        filling = 1'b1;
    int        stall_left = 0;

    route_table_prefix_match_core #(
        .TABLE_DEPTH(ROUTE_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 400000);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_out_word route_predict(t_in_word w);
        t_out_word   r;
        logic [31:0] best;
        bit          hit;
        int          i;
        r.next_hop = HOP_NONE;
        r.status = ST_BAD;
        hit = 1'b0;
        best = '0;
        case (w.func)
            FN_LOOKUP: begin
                for (i = 0; i < route_count; i++) begin
                    if ((tbl_mask[i] & w.lookup_address) == tbl_net[i] &&
                        (!hit || tbl_mask[i] >= best)) begin
                        best = tbl_mask[i];
                        r.next_hop = tbl_hop[i];
                        hit = 1'b1;
                    end
                end
                r.status = hit ? ST_DONE : ST_MISS;
            end
            FN_ADD: begin
                if (route_count >= ROUTE_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = 0; i < route_count; i++) begin
                        if (tbl_net[i] == w.route_net && tbl_mask[i] == w.route_mask &&
                            tbl_hop[i] == w.route_hop)
                            hit = 1'b1;
                    end
                    if (hit) begin
                        r.status = ST_DUP;
                    end else begin
                        tbl_mask[route_count] = w.route_mask;
                        tbl_net[route_count] = w.route_net;
                        tbl_hop[route_count] = w.route_hop;
                        route_count++;
                        r.status = ST_DONE;
                    end
                end
            end
            FN_DELETE: begin
                if (route_count != 0 && int'(w.entry_index) < route_count) begin
                    // close the gap
                    for (i = int'(w.entry_index); i + 1 < route_count; i++) begin
                        tbl_mask[i] = tbl_mask[i + 1];
                        tbl_net[i] = tbl_net[i + 1];
                        tbl_hop[i] = tbl_hop[i + 1];
                    end
                    route_count--;
                    r.status = ST_DONE;
                end
            end
            default: r.status = ST_BAD;
        endcase
        r.entries_used = 6'(route_count);
        return r;
    endfunction

    function automatic t_in_word make_word(logic [1:0] fn, logic [31:0] addr, logic [31:0] net,
                                           logic [31:0] mask, logic [31:0] hop,
                                           logic [4:0] idx);
        t_in_word w;
        w.func = fn;
        w.lookup_address = addr;
        w.route_net = net;
        w.route_mask = mask;
        w.route_hop = hop;
        w.entry_index = idx;
        return w;
    endfunction

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
    endfunction

    // a few shared prefixes so that routes nest and overlap
    function automatic logic [31:0] pick_anchor();
        logic [31:0] base;
        case ($urandom_range(0, 3))
            0: base = 32'h0a00_0000;
            1: base = 32'hc0a8_0000;
            2: base = 32'hac10_0000;
            default: base = $urandom;
        endcase
        return base | ($urandom & 32'h0003_0303);
    endfunction

    function automatic t_in_word noise_word();
        return make_word(2'($urandom), $urandom, $urandom, $urandom, $urandom, 5'($urandom));
    endfunction

    function automatic t_in_word random_add_word();
        t_in_word    w;
        int          roll;
        int          k;
        logic [31:0] m;
        w = noise_word();
        w.func = FN_ADD;
        roll = $urandom_range(0, 99);
        if (roll < 10 && route_count > 0) begin
            k = $urandom_range(0, route_count - 1);
            w.route_net = tbl_net[k];
            w.route_mask = tbl_mask[k];
            w.route_hop = tbl_hop[k];
        end else begin
            m = (roll < 20) ? $urandom : prefix_mask($urandom_range(0, 32));
            w.route_mask = m;
            // net bits outside the mask make a route that never matches
            w.route_net = (roll < 24) ? $urandom : (pick_anchor() & m);
            w.route_hop = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
        end
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       roll;
        int       k;
        if (route_count == ROUTE_SLOTS && $urandom_range(0, 2) == 0)
            filling = 1'b0;
        else if (route_count <= 1)
            filling = 1'b1;
        roll = $urandom_range(0, 99);
        if ((filling && roll < 55) || (!filling && roll < 10))
            return random_add_word();
        w = noise_word();
        if ((filling && roll < 90) || (!filling && roll < 45)) begin
            w.func = FN_LOOKUP;
            if (route_count > 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, route_count - 1);
                w.lookup_address = tbl_net[k] | ($urandom & ~tbl_mask[k]);
            end else if ($urandom_range(0, 1) == 0) begin
                w.lookup_address = pick_anchor();
            end
        end else if (roll < 95) begin
            w.func = FN_DELETE;
            if (route_count > 0 && $urandom_range(0, 5) != 0)
                w.entry_index = 5'($urandom_range(0, route_count - 1));
        end else begin
            w.func = FN_UNUSED;
        end
        return w;
    endfunction

    task automatic push_row(t_in_word w, bit typed, t_out_word result);
        t_dir_row row;
        row.word = w;
        row.typed = typed;
        row.result = result;
        dir_rows.push_back(row);
    endtask

    // hold the word until accepted, then queue its expected result
    task automatic send_word(t_in_word w, bit typed, t_out_word result);
        t_out_word predicted;
        if ($urandom_range(0, 59) == 0)
            send_calm = ~send_calm;
        if (!quiet_tail && !send_calm && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = route_predict(w);
        pending_results.push_back(typed ? result : predicted);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_MSGS)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            stall_calm = ~stall_calm;
        if (stall_left == 0 && !quiet_tail && !stall_calm && $urandom_range(0, 99) < 12)
            stall_left = $urandom_range(1, 17);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_result
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none pending", o_out_word.next_hop, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.next_hop !== want.next_hop)
                    report_mismatch("next_hop", o_out_word.next_hop, want.next_hop);
                if (o_out_word.status !== want.status)
                    report_mismatch("status", 32'(o_out_word.status), 32'(want.status));
                if (o_out_word.entries_used !== want.entries_used)
                    report_mismatch("entries_used", 32'(o_out_word.entries_used),
                                    32'(want.entries_used));
            end
        end
    end

    initial begin : stimulus
        t_out_word none;
        int        n;
        none = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, refused requests
        push_row(make_word(FN_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0), 1'b1,
                 '{HOP_NONE, ST_MISS, 6'd0});
        push_row(make_word(FN_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 5'd0), 1'b1,
                 '{HOP_NONE, ST_MISS, 6'd0});
        push_row(make_word(FN_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0), 1'b1,
                 '{HOP_NONE, ST_BAD, 6'd0});
        push_row(make_word(FN_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, 5'd31), 1'b1,
                 '{HOP_NONE, ST_BAD, 6'd0});
        push_row(make_word(FN_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                           32'hffff_ffff, 5'd31), 1'b1, '{HOP_NONE, ST_BAD, 6'd0});
        // default route with direct hop, then its duplicate
        push_row(make_word(FN_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0), 1'b1,
                 '{HOP_NONE, ST_DONE, 6'd1});
        push_row(make_word(FN_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0), 1'b1,
                 '{HOP_NONE, ST_DUP, 6'd1});
        push_row(make_word(FN_ADD, 32'h0, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_0001, 5'd0),
                 1'b1, '{HOP_NONE, ST_DONE, 6'd2});
        push_row(make_word(FN_ADD, 32'h0, 32'h0a01_0000, 32'hffff_0000, 32'h0a01_0001, 5'd0),
                 1'b1, '{HOP_NONE, ST_DONE, 6'd3});
        push_row(make_word(FN_ADD, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 5'd0),
                 1'b1, '{HOP_NONE, ST_DONE, 6'd4});
        // mask with a hole in it
        push_row(make_word(FN_ADD, 32'h0, 32'h0a00_0a00, 32'hff00_ff00, 32'h1234_5678, 5'd0),
                 1'b1, '{HOP_NONE, ST_DONE, 6'd5});
        push_row(make_word(FN_LOOKUP, 32'h0a01_0203, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        push_row(make_word(FN_LOOKUP, 32'h0a02_0304, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        push_row(make_word(FN_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        push_row(make_word(FN_LOOKUP, 32'h0b00_0000, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        push_row(make_word(FN_LOOKUP, 32'h0a7f_0aff, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        // same prefix, other hop: the later route wins the tie
        push_row(make_word(FN_ADD, 32'h0, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_00fe, 5'd0),
                 1'b1, '{HOP_NONE, ST_DONE, 6'd6});
        push_row(make_word(FN_LOOKUP, 32'h0a09_0909, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        push_row(make_word(FN_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, 5'd6), 1'b1,
                 '{HOP_NONE, ST_BAD, 6'd6});
        push_row(make_word(FN_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0), 1'b1,
                 '{HOP_NONE, ST_DONE, 6'd5});
        push_row(make_word(FN_LOOKUP, 32'h0b00_0000, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);
        push_row(make_word(FN_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, 5'd4), 1'b1,
                 '{HOP_NONE, ST_DONE, 6'd4});
        push_row(make_word(FN_LOOKUP, 32'h0a02_0304, 32'h0, 32'h0, 32'h0, 5'd0), 1'b0, none);

        foreach (dir_rows[r])
            send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].result);

        // fill to capacity; the full check beats the duplicate check
        while (route_count < ROUTE_SLOTS)
            send_word(random_add_word(), 1'b0, none);
        send_word(make_word(FN_ADD, 32'h0, 32'h0101_0000, 32'hffff_0000, 32'h0101_0101, 5'd0),
                  1'b1, '{HOP_NONE, ST_FULL, 6'd32});
        send_word(make_word(FN_ADD, 32'h0, tbl_net[0], tbl_mask[0], tbl_hop[0], 5'd0),
                  1'b1, '{HOP_NONE, ST_FULL, 6'd32});
        send_word(make_word(FN_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, 5'd31), 1'b1,
                  '{HOP_NONE, ST_DONE, 6'd31});

        for (n = 0; n < RANDOM_WORDS; n++) begin
            quiet_tail = (n >= RANDOM_WORDS - TAIL_WORDS);
            send_word(random_word(), 1'b0, none);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
